// ===== hdl/tilt_orientation_classifier_defines.svh =====
// assertion macros for the tilt orientation classifier checker
`ifndef TILT_ORIENTATION_CLASSIFIER_DEFINES_SVH
`define TILT_ORIENTATION_CLASSIFIER_DEFINES_SVH

// implication checked in the same cycle, ignored while in reset
`define TOC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("toc check failed");

// implication checked in the next cycle, ignored while in reset
`define TOC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("toc check failed");

// condition that must follow a reset cycle
`define TOC_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("toc reset check failed");

`endif

// ===== hdl/toc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc_pkg
// Shared constants, types and the arctangent table for the tilt classifier.
// ----------------------------------------------------------------------------
package toc_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int ACC_BITS  = 24;   // angle accumulator fraction bits
  localparam int TAB_LEN   = 24;
  localparam int CW        = 44;   // cordic x/y width
  localparam int ZW        = 34;   // cordic angle width
  localparam int SQ_STAGES = 16;   // one root bit per stage

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_PITCH_LIMIT = 2'd0;
  localparam logic [1:0] REG_ROLL_INNER  = 2'd1;
  localparam logic [1:0] REG_ROLL_OUTER  = 2'd2;

  localparam logic [6:0] PITCH_LIMIT_RST = 7'd45;
  localparam logic [7:0] ROLL_INNER_RST  = 8'd45;
  localparam logic [7:0] ROLL_OUTER_RST  = 8'd135;

  localparam logic [2:0] ORI_FINGER_UP   = 3'd0;
  localparam logic [2:0] ORI_FINGER_DOWN = 3'd1;
  localparam logic [2:0] ORI_THUMB_UP    = 3'd2;
  localparam logic [2:0] ORI_PALM_DOWN   = 3'd3;
  localparam logic [2:0] ORI_THUMB_DOWN  = 3'd4;
  localparam logic [2:0] ORI_PALM_UP     = 3'd5;
  localparam logic [2:0] ORI_NONE        = 3'd6;

  // atan(2^-i) in degrees times 2^24
  localparam logic [30:0] ATAN_TAB [TAB_LEN] = '{
    31'd754974720, 31'd445687602, 31'd235489089, 31'd119537938,
    31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
    31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
    31'd234684,    31'd117342,    31'd58671,     31'd29335,
    31'd14668,     31'd7334,      31'd3667,      31'd1833,
    31'd917,       31'd458,       31'd229,       31'd115
  };

  typedef struct packed {
    logic p_nneg;   // pitch numerator negative
    logic p_nz;     // pitch numerator zero
    logic p_dz;     // pitch denominator zero
    logic r_nneg;
    logic r_dneg;
    logic r_nz;
    logic r_dz;
  } toc_flags_t;

endpackage

// ===== hdl/toc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc_in_if
// Sample channel: valid/ready with one accelerometer word.
// ----------------------------------------------------------------------------
interface toc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

// ===== hdl/toc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc_out_if
// Result channel: valid/ready with pitch, roll and orientation code.
// ----------------------------------------------------------------------------
interface toc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic        [2:0]  orientation;

  modport source (output valid, output pitch_angle, output roll_angle,
                  output orientation, input ready);
  modport sink   (input valid, input pitch_angle, input roll_angle,
                  input orientation, output ready);
endinterface

// ===== hdl/toc_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc_cordic
// Pipelined vectoring cordic, one rotation per register stage.
// ----------------------------------------------------------------------------
module toc_cordic #(
  parameter int STAGES = toc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [toc_pkg::CW-1:0] x_in,
  input  logic signed [toc_pkg::CW-1:0] y_in,
  output logic signed [toc_pkg::ZW-1:0] z_out
);
  import toc_pkg::*;

  logic signed [CW-1:0] x_r [STAGES];
  logic signed [CW-1:0] y_r [STAGES];
  logic signed [ZW-1:0] z_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xp, yp;
    logic signed [ZW-1:0] zp;
    logic signed [ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign xp = x_in;
      assign yp = y_in;
      assign zp = '0;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    assign ang = signed'(ZW'(ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        if (yp >= 0) begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          z_r[i] <= zp + ang;
        end else begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          z_r[i] <= zp - ang;
        end
      end
    end
  end

  assign z_out = z_r[STAGES-1];

endmodule

// ===== hdl/tilt_orientation_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_orientation_classifier
// Pitch and roll from one accelerometer sample, then hand orientation.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while out_ch does not stall, and returns one
// result per sample, in order. Its registers, in order: input
// register, two stages of squaring and summing, sixteen square-root stages
// (one root bit each), operand setup, the two cordic pipelines running side
// by side, angle fixup, and the classify/output register. The whole pipeline
// advances whenever the output register is empty or being taken, so in_ch
// ready follows out_ch ready. Angles are degrees times 2^ANGLE_FRAC_BITS;
// limits are programmed in whole degrees over the APB port at 0x0, 0x4, 0x8.
module tilt_orientation_classifier #(
  parameter int ANGLE_FRAC_BITS = toc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = toc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  toc_in_if.sink                     in_ch,
  toc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [toc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import toc_pkg::*;

  localparam int ANG_W = ANGLE_FRAC_BITS + 10;
  localparam int SH    = ACC_BITS - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] NINETY     = ZW'(90) <<< ACC_BITS;
  localparam logic signed [ZW-1:0] ONE_EIGHTY = ZW'(180) <<< ACC_BITS;
  localparam logic signed [ZW-1:0] HALF       = ZW'(1) <<< (SH - 1);

  // ---------------- configuration ----------------
  logic [6:0] pitch_limit_r;
  logic [7:0] roll_inner_r;
  logic [7:0] roll_outer_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_limit_r <= PITCH_LIMIT_RST;
      roll_inner_r  <= ROLL_INNER_RST;
      roll_outer_r  <= ROLL_OUTER_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PITCH_LIMIT: pitch_limit_r <= pwdata[6:0];
        REG_ROLL_INNER:  roll_inner_r  <= pwdata[7:0];
        REG_ROLL_OUTER:  roll_outer_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PITCH_LIMIT: prdata = {25'd0, pitch_limit_r};
      REG_ROLL_INNER:  prdata = {24'd0, roll_inner_r};
      REG_ROLL_OUTER:  prdata = {24'd0, roll_outer_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic o_v_r;

  assign en          = !o_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: input register
  logic               v1_r;
  logic signed [15:0] x1_r, y1_r, z1_r;
  // stage 2: squares
  logic               v2_r;
  logic signed [15:0] x2_r, y2_r, z2_r;
  logic [31:0]        sqy_r, sqz_r;
  // stage 3: sum
  logic               v3_r;
  logic signed [15:0] x3_r, y3_r, z3_r;
  logic [31:0]        sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= in_ch.accel_x;
      y1_r  <= in_ch.accel_y;
      z1_r  <= in_ch.accel_z;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
      sqy_r <= 32'(unsigned'(32'(y1_r * y1_r)));
      sqz_r <= 32'(unsigned'(32'(z1_r * z1_r)));
      x3_r  <= x2_r;
      y3_r  <= y2_r;
      z3_r  <= z2_r;
      sum_r <= sqy_r + sqz_r;
    end
  end

  // ---------------- square root, one bit per stage ----------------
  logic               sq_v_r   [SQ_STAGES];
  logic [33:0]        sq_rem_r [SQ_STAGES];
  logic [15:0]        sq_root_r[SQ_STAGES];
  logic signed [15:0] sq_x_r   [SQ_STAGES];
  logic signed [15:0] sq_y_r   [SQ_STAGES];
  logic signed [15:0] sq_z_r   [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam int B = SQ_STAGES - 1 - k;
    logic               vp;
    logic [33:0]        remp, trial;
    logic [15:0]        rootp;
    logic signed [15:0] xp, yp, zp;

    if (k == 0) begin : g_first
      assign vp    = v3_r;
      assign remp  = {2'b00, sum_r};
      assign rootp = '0;
      assign xp    = x3_r;
      assign yp    = y3_r;
      assign zp    = z3_r;
    end else begin : g_next
      assign vp    = sq_v_r[k-1];
      assign remp  = sq_rem_r[k-1];
      assign rootp = sq_root_r[k-1];
      assign xp    = sq_x_r[k-1];
      assign yp    = sq_y_r[k-1];
      assign zp    = sq_z_r[k-1];
    end

    // (root + 2^b)^2 - root^2
    assign trial = (34'(rootp) << (B + 1)) + (34'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (remp >= trial) begin
          sq_rem_r[k]  <= remp - trial;
          sq_root_r[k] <= rootp | (16'd1 << B);
        end else begin
          sq_rem_r[k]  <= remp;
          sq_root_r[k] <= rootp;
        end
        sq_x_r[k] <= xp;
        sq_y_r[k] <= yp;
        sq_z_r[k] <= zp;
      end
    end
  end

  // ---------------- operand setup ----------------
  logic               sx_neg, sy_neg, sz_neg;
  logic [16:0]        ax_mag, ay_mag, az_mag;
  logic signed [15:0] sx, sy, sz;
  logic [15:0]        sroot;
  logic               p_v_r;
  logic signed [CW-1:0] px_r, py_r, rx_r, ry_r;
  toc_flags_t         p_fl_r;

  assign sx     = sq_x_r[SQ_STAGES-1];
  assign sy     = sq_y_r[SQ_STAGES-1];
  assign sz     = sq_z_r[SQ_STAGES-1];
  assign sroot  = sq_root_r[SQ_STAGES-1];
  assign sx_neg = sx[15];
  assign sy_neg = sy[15];
  assign sz_neg = sz[15];
  assign ax_mag = sx_neg ? 17'(-18'(sx)) : 17'(sx);
  assign ay_mag = sy_neg ? 17'(-18'(sy)) : 17'(sy);
  assign az_mag = sz_neg ? 17'(-18'(sz)) : 17'(sz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= sq_v_r[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r          <= signed'(CW'(sroot) << ACC_BITS);
      py_r          <= signed'(CW'(ax_mag) << ACC_BITS);
      rx_r          <= signed'(CW'(az_mag) << ACC_BITS);
      ry_r          <= signed'(CW'(ay_mag) << ACC_BITS);
      // pitch numerator is -x
      p_fl_r.p_nneg <= (sx > 0);
      p_fl_r.p_nz   <= (sx == 0);
      p_fl_r.p_dz   <= (sroot == 0);
      p_fl_r.r_nneg <= sy_neg;
      p_fl_r.r_dneg <= sz_neg;
      p_fl_r.r_nz   <= (sy == 0);
      p_fl_r.r_dz   <= (sz == 0);
    end
  end

  // ---------------- cordic pipelines ----------------
  logic signed [ZW-1:0] pz, rz;
  logic                 c_v_r  [CORDIC_STAGES];
  toc_flags_t           c_fl_r [CORDIC_STAGES];

  toc_cordic #(.STAGES(CORDIC_STAGES)) u_pitch_cordic (
    .clk(clk), .en(en), .x_in(px_r), .y_in(py_r), .z_out(pz)
  );

  toc_cordic #(.STAGES(CORDIC_STAGES)) u_roll_cordic (
    .clk(clk), .en(en), .x_in(rx_r), .y_in(ry_r), .z_out(rz)
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r[i] <= 1'b0;
      end else if (en) begin
        c_v_r[i] <= (i == 0) ? p_v_r : c_v_r[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_fl_r[i] <= (i == 0) ? p_fl_r : c_fl_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // ---------------- angle fixup ----------------
  function automatic logic signed [ANG_W-1:0] fix_angle(
    logic signed [ZW-1:0] z, logic nz, logic dz, logic nneg, logic dneg);
    logic signed [ZW-1:0] t;
    logic signed [ZW-1:0] r;
    if (nz && dz) begin
      return '0;
    end
    if (nz) begin
      t = '0;
    end else if (dz) begin
      t = NINETY;
    end else if (z < 0) begin
      t = '0;
    end else if (z > NINETY) begin
      t = NINETY;
    end else begin
      t = z;
    end
    if (dneg) begin
      t = ONE_EIGHTY - t;
    end
    r = (t + HALF) >>> SH;
    return nneg ? -r[ANG_W-1:0] : r[ANG_W-1:0];
  endfunction

  toc_flags_t             cf;
  logic                   f_v_r;
  logic signed [ANG_W-1:0] f_pitch_r, f_roll_r;

  assign cf = c_fl_r[CORDIC_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= c_v_r[CORDIC_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_pitch_r <= fix_angle(pz, cf.p_nz, cf.p_dz, cf.p_nneg, 1'b0);
      f_roll_r  <= fix_angle(rz, cf.r_nz, cf.r_dz, cf.r_nneg, cf.r_dneg);
    end
  end

  // ---------------- classify and output register ----------------
  logic signed [ANG_W-1:0] pl, ri, ro, full;
  logic [2:0]              ori;
  logic [14:0]             o_pitch_r;
  logic [15:0]             o_roll_r;
  logic [2:0]              o_ori_r;

  assign pl   = signed'(ANG_W'(pitch_limit_r) << ANGLE_FRAC_BITS);
  assign ri   = signed'(ANG_W'(roll_inner_r) << ANGLE_FRAC_BITS);
  assign ro   = signed'(ANG_W'(roll_outer_r) << ANGLE_FRAC_BITS);
  assign full = signed'(ANG_W'(180) << ANGLE_FRAC_BITS);

  always_comb begin
    if (f_pitch_r > pl) begin
      ori = ORI_FINGER_UP;
    end else if (f_pitch_r < -pl) begin
      ori = ORI_FINGER_DOWN;
    end else if (f_roll_r >= -ro && f_roll_r <= -ri) begin
      ori = ORI_THUMB_UP;
    end else if (f_roll_r >= -ri && f_roll_r <= ri) begin
      ori = ORI_PALM_DOWN;
    end else if (f_roll_r >= ri && f_roll_r <= ro) begin
      ori = ORI_THUMB_DOWN;
    end else if ((f_roll_r >= ro && f_roll_r <= full) ||
                 (f_roll_r >= -full && f_roll_r <= -ro)) begin
      ori = ORI_PALM_UP;
    end else begin
      ori = ORI_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_pitch_r <= 15'(f_pitch_r);
      o_roll_r  <= 16'(f_roll_r);
      o_ori_r   <= ori;
    end
  end

  assign out_ch.valid       = o_v_r;
  assign out_ch.pitch_angle = signed'(o_pitch_r);
  assign out_ch.roll_angle  = signed'(o_roll_r);
  assign out_ch.orientation = o_ori_r;

endmodule

// ===== hdl/toc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toc_checker
// Port-level checks for the tilt classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "tilt_orientation_classifier_defines.svh"

module toc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] out_pitch,
  input logic [15:0] out_roll,
  input logic [2:0]  out_ori
);
  import toc_pkg::*;

  `TOC_ASSERT_RESET(a_out_idle_after_reset, !out_valid)

  // input side stalls exactly when a result is held
  `TOC_ASSERT_SAME(a_ready_follows_out, 1'b1, in_ready == (out_ready || !out_valid))

  `TOC_ASSERT_SAME(a_ori_code, out_valid, out_ori <= ORI_NONE)

  `TOC_ASSERT_NEXT(a_hold_word, out_valid && !out_ready,
    out_valid && $stable(out_pitch) && $stable(out_roll) && $stable(out_ori))

endmodule

bind tilt_orientation_classifier toc_checker u_toc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_pitch(out_ch.pitch_angle),
  .out_roll (out_ch.roll_angle),
  .out_ori  (out_ch.orientation)
);
